/* rtl/core/bda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ascii unit
// sizes of the binary and decimal words, ascii base, sequencer states
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int NUM_BITS   = 32;
  localparam int DEC_DIGITS = 10;  // most digits of a 32-bit unsigned value
  localparam int MAX_DIGITS = 10;  // most digits emitted per number

  // emitted digit count clamped to 1 .. DEC_DIGITS
  localparam int DIGIT_LIMIT = (MAX_DIGITS < 1) ? 1 :
                               ((MAX_DIGITS > DEC_DIGITS) ? DEC_DIGITS : MAX_DIGITS);

  localparam int BCD_BITS  = 4 * DEC_DIGITS;
  localparam int CNT_BITS  = $clog2(NUM_BITS);
  localparam int IDX_BITS  = $clog2(DEC_DIGITS);
  localparam int CHAR_BITS = 6;
  localparam int DATA_BITS = 8;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'h30;
  localparam logic [3:0]           DIGIT_NINE = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } bda_state_t;

endpackage

/* rtl/core/binary_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: 32-bit binary to decimal ascii text
// iterative double dabble followed by a digit streamer
// ----------------------------------------------------------------------------
// usage
//   slave channel: one beat carries one unsigned 32-bit number in s_tdata.
//   master channel: one beat per decimal digit, most significant first,
//   no leading zeros (zero gives a single '0'); m_tdata[5:0] holds the
//   ascii character and m_tlast marks the least significant digit.
//   timing: after the input beat the shared add-3/shift unit runs over
//   all input bits (one bit per cycle), the scan state locates the leading
//   digit, then digits leave one per cycle unless the receiver holds off.
//   s_tready is high only while the sequencer is idle.
//   at most MAX_DIGITS digits leave; larger numbers keep their low digits.
//   reset: rst clears the sequencer and the output valid, no number is in
//   flight afterwards.
//   stall: a held-off digit stays in the output register and the streamer
//   waits; the next number is taken once its last digit is in the output
//   register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit (
  input  logic                               clk,
  input  logic                               rst,
  // slave side, tdata fields from bit 0: value[31:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bda_pkg::NUM_BITS-1:0]       s_tdata,
  // master side, tdata fields from bit 0: digit_char[5:0], zero pad [7:6]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bda_pkg::DATA_BITS-1:0]      m_tdata,
  output logic                               m_tlast
);

  import bda_pkg::*;

  // sequencer and working registers
  bda_state_t            state, state_next;
  logic [CNT_BITS-1:0]   bit_cnt, bit_cnt_next;
  logic [BCD_BITS-1:0]   bcd, bcd_next;
  logic [NUM_BITS-1:0]   bin, bin_next;
  logic [IDX_BITS-1:0]   idx, idx_next;

  // output register
  logic                  out_valid, out_valid_next;
  logic [CHAR_BITS-1:0]  out_char, out_char_next;
  logic                  out_last, out_last_next;

  // add-3 correction on every bcd digit, done in parallel
  logic [BCD_BITS-1:0]   adj;
  // index of the most significant nonzero digit (0 when the value is zero)
  logic [IDX_BITS-1:0]   top;
  logic [3:0]            cur_digit;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    top = '0;
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        top = IDX_BITS'(i);
      end
    end
  end

  assign cur_digit = bcd[{idx, 2'b00} +: 4];

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    bcd_next       = bcd;
    bin_next       = bin;
    idx_next       = idx;
    out_valid_next = out_valid;
    out_char_next  = out_char;
    out_last_next  = out_last;

    // a taken digit frees the output register
    if (m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          bin_next     = s_tdata;
          bcd_next     = '0;
          bit_cnt_next = '0;
          state_next   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        // one double dabble step: correct, then shift in the next bit
        bcd_next     = {adj[BCD_BITS-2:0], bin[NUM_BITS-1]};
        bin_next     = {bin[NUM_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == CNT_BITS'(NUM_BITS - 1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // first digit to send, clamped to the digit limit
        if (top > IDX_BITS'(DIGIT_LIMIT - 1)) begin
          idx_next = IDX_BITS'(DIGIT_LIMIT - 1);
        end else begin
          idx_next = top;
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_char_next  = ASCII_ZERO | {2'b00, cur_digit};
          out_last_next  = (idx == '0);
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    bit_cnt  <= bit_cnt_next;
    bcd      <= bcd_next;
    bin      <= bin_next;
    idx      <= idx_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(DATA_BITS - CHAR_BITS){1'b0}}, out_char};
  assign m_tlast  = out_last;

endmodule

/* rtl/core/bda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for the binary to decimal ascii unit
// watches both stream channels and is bound to the top level
// ----------------------------------------------------------------------------
module bda_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bda_pkg::NUM_BITS-1:0]   s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bda_pkg::DATA_BITS-1:0]  m_tdata,
  input logic                           m_tlast
);

  import bda_pkg::*;

  // input closes for the conversion after every accepted number
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted number");

  // a digit beat is always an ascii decimal character
  a_ascii_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[DATA_BITS-1:4] == 4'h3 && m_tdata[3:0] <= DIGIT_NINE))
    else $error("output beat is not an ascii digit");

  // while a number is still being sent the input stays closed
  a_no_accept_mid_number: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input open before the last digit was produced");

  // a stalled digit beat stays presented
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (.*);

/* dv/binary_to_decimal_ascii_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit_tb: self-checking bench for the decimal text unit
// numbers go in on the slave stream; every digit beat that comes out is
// compared against digits computed here by repeated division by ten
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit_tb;

  import bda_pkg::*;

  localparam int CLK_HALF      = 4;       // 8 ns period
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PCT      = 7;       // chance of an idle cycle per side
  localparam int RANDOM_ITEMS  = 360;
  localparam int LONG_HOLD     = 400;     // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES  = 60;      // idle run after the last owed digit
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // one expected digit beat on the master side
  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  // holds the digits still owed by the unit, oldest first
  class digit_scoreboard;
    digit_beat_t owed_digits[$];
    int          failures;
    int          reported;

    function new();
      failures = 0;
      reported = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("tb: mismatch: %s", msg);
      end
    endfunction

    // accepted number: push its digits, most significant first
    function void note_value(logic [NUM_BITS-1:0] number);
      logic [3:0]          lsd_first [DEC_DIGITS];
      logic [NUM_BITS-1:0] rest;
      int                  count;
      int                  keep;
      digit_beat_t         beat;
      rest  = number;
      count = 0;
      // zero still gives one digit
      do begin
        lsd_first[count] = 4'(rest % 10);
        rest             = rest / 10;
        count++;
      end while (rest != 0 && count < DEC_DIGITS);
      keep = (count < DIGIT_LIMIT) ? count : DIGIT_LIMIT;
      for (int k = 0; k < keep; k++) begin
        beat.digit_char = ASCII_ZERO | {2'b00, lsd_first[keep - 1 - k]};
        beat.last_digit = (k == keep - 1);
        owed_digits.push_back(beat);
      end
    endfunction

    function void check_digit(logic [DATA_BITS-1:0] data, logic last);
      digit_beat_t want;
      if (owed_digits.size() == 0) begin
        flag($sformatf("unexpected digit beat tdata=%h tlast=%b", data, last));
        return;
      end
      want = owed_digits.pop_front();
      if (data[CHAR_BITS-1:0] !== want.digit_char)
        flag($sformatf("digit_char expected %h actual %h",
                       want.digit_char, data[CHAR_BITS-1:0]));
      if (data[DATA_BITS-1:CHAR_BITS] !== '0)
        flag($sformatf("tdata pad expected 0 actual %b",
                       data[DATA_BITS-1:CHAR_BITS]));
      if (last !== want.last_digit)
        flag($sformatf("last_digit expected %b actual %b", want.last_digit, last));
    endfunction

    function int pending();
      return owed_digits.size();
    endfunction

    function void close();
      if (owed_digits.size() != 0)
        flag($sformatf("%0d digit beats never arrived", owed_digits.size()));
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [NUM_BITS-1:0]  s_tdata  = '0;   // value[31:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_BITS-1:0] m_tdata;         // digit_char[5:0], zero pad [7:6]
  logic                 m_tlast;

  digit_scoreboard sb = new();

  bit calm        = 1'b0;  // no idling on either side while set
  int hold_cycles = 0;     // receiver hold-off still to run
  int cycle_count = 0;

  logic [NUM_BITS-1:0] corner_values [20] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd12345,
    32'd99999999, 32'd100000000, 32'd999999999, 32'd1000000000,
    32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4294967294,
    32'd4294967295, 32'h55555555, 32'hAAAAAAAA, 32'd4000000000
  };

  binary_to_decimal_ascii_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // digit sink: check the beat taken at this edge, then pick the next tready
  initial begin : digit_sink
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready)
        sb.check_digit(m_tdata, m_tlast);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one number, with random idle cycles in front, until it is taken
  task automatic send_value(input logic [NUM_BITS-1:0] number);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= number;
    do begin
      @(posedge clk);
    end while (s_tready !== 1'b1);
    sb.note_value(number);
  endtask

  // stop offering and wait until every owed digit has come out
  task automatic wait_digits_done();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random number with a spread over digit counts and bit patterns
  function automatic logic [NUM_BITS-1:0] pick_value();
    longint lo;
    longint hi;
    int     digits;
    int     mode;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      return $urandom;
    end else if (mode <= 6) begin
      // uniform within a random decade
      digits = $urandom_range(DEC_DIGITS, 1);
      lo = 1;
      for (int k = 1; k < digits; k++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (digits == 1) lo = 0;
      if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
      return NUM_BITS'(lo + (longint'($urandom) % (hi - lo + 1)));
    end else if (mode == 7) begin
      return $urandom_range(20);
    end else if (mode == 8) begin
      // just around a power of ten
      lo = 1;
      digits = $urandom_range(DEC_DIGITS - 1);
      for (int k = 0; k < digits; k++) lo = lo * 10;
      return NUM_BITS'(lo + $urandom_range(4) - 2);
    end else begin
      // sparse or dense bit patterns
      return $urandom_range(1) ? ($urandom & $urandom) : ($urandom | $urandom);
    end
  endfunction

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, then let everything drain
    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_digits_done();
    @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold-off while numbers keep being offered
      if (i == 120) hold_cycles = LONG_HOLD;
      calm = (i >= 200 && i < 280);
      if (i == 300) begin
        wait_digits_done();
        @(posedge clk);
      end
      send_value(pick_value());
    end
    calm = 1'b0;

    wait_digits_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close();
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
